// ===== hw/rtl/blpg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blpg_pkg
// Shared types and constants of the line pixel generator.
// ----------------------------------------------------------------------------
package blpg_pkg;

    localparam int CFG_BITS     = 13;
    localparam int CFG_IDX_BITS = 1;
    localparam int ADDR_BITS    = 24;
    localparam int COLOR_BITS   = 24;
    localparam int CHAN_BITS    = 8;
    localparam int AREA_BITS    = 2 * CFG_BITS;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_BITS-1:0]  RESET_FRAME_WIDTH  = 13'd1024;
    localparam logic [CFG_BITS-1:0]  RESET_FRAME_HEIGHT = 13'd768;
    localparam logic [AREA_BITS-1:0] RESET_FRAME_AREA   = 26'd786432;

    // item actions
    localparam logic ACTION_LOAD = 1'b0;
    localparam logic ACTION_STEP = 1'b1;

    typedef struct packed {
        logic [CFG_BITS-1:0]  width;
        logic [CFG_BITS-1:0]  height;
        logic [AREA_BITS-1:0] area;
    } frame_cfg_t;

endpackage

// ===== hw/rtl/blpg_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blpg_cfg
// Frame size registers and the registered frame area.
// ----------------------------------------------------------------------------
module blpg_cfg
    import blpg_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_data,
    output frame_cfg_t              frame_cfg
);

    logic [CFG_BITS-1:0]  width_reg;
    logic [CFG_BITS-1:0]  height_reg;
    logic [AREA_BITS-1:0] area_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= RESET_FRAME_WIDTH;
            height_reg <= RESET_FRAME_HEIGHT;
            area_reg   <= RESET_FRAME_AREA;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_FRAME_WIDTH:  width_reg  <= cfg_data;
                    CFG_FRAME_HEIGHT: height_reg <= cfg_data;
                    default: ;
                endcase
            end
            // follows the size registers in the following cycle
            area_reg <= width_reg * height_reg;
        end
    end

    assign frame_cfg.width  = width_reg;
    assign frame_cfg.height = height_reg;
    assign frame_cfg.area   = area_reg;

endmodule

// ===== hw/rtl/blpg_line.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blpg_line
// Line setup on load and Bresenham error stepping on each pixel.
// ----------------------------------------------------------------------------
module blpg_line
    import blpg_pkg::*;
#(
    parameter int CB = 13
)
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load_en,
    input  logic                  step_en,
    input  logic signed [CB-1:0]  x_start,
    input  logic signed [CB-1:0]  y_start,
    input  logic signed [CB-1:0]  x_end,
    input  logic signed [CB-1:0]  y_end,
    input  logic [COLOR_BITS-1:0] color_in,
    output logic                  active,
    output logic [CB-1:0]         pix_x,
    output logic [CB-1:0]         pix_y,
    output logic                  pix_last,
    output logic [COLOR_BITS-1:0] color_out
);

    localparam int EW = CB + 2;

    logic [CB-1:0]         major_pos_reg;
    logic [CB-1:0]         major_end_reg;
    logic [CB-1:0]         minor_pos_reg;
    logic                  step_down_reg;
    logic signed [EW-1:0]  acc_reg;
    logic [CB:0]           incr_reg;
    logic [CB-1:0]         span_reg;
    logic                  swapped_reg;
    logic                  active_reg;
    logic [COLOR_BITS-1:0] color_reg;

    logic [CB-1:0]        a0, b0, a1, b1;
    logic signed [CB:0]   da, db, dmin;
    logic [CB:0]          mag_a, mag_b, mag_min;
    logic                 swap;
    logic [CB-1:0]        p0, q0, p1, q1;
    logic [CB-1:0]        ma0, mi0, ma1, mi1;
    logic signed [EW-1:0] acc_sum;
    logic signed [EW-1:0] span_ext;
    logic                 minor_move;

    // negative coordinates clamp to 1
    always_comb begin
        a0 = x_start[CB-1] ? CB'(1) : x_start;
        b0 = y_start[CB-1] ? CB'(1) : y_start;
        a1 = x_end[CB-1]   ? CB'(1) : x_end;
        b1 = y_end[CB-1]   ? CB'(1) : y_end;
    end

    always_comb begin
        da    = $signed({1'b0, a0}) - $signed({1'b0, a1});
        db    = $signed({1'b0, b0}) - $signed({1'b0, b1});
        mag_a = da[CB] ? (CB+1)'(-da) : (CB+1)'(da);
        mag_b = db[CB] ? (CB+1)'(-db) : (CB+1)'(db);
        swap  = mag_a < mag_b;
        p0 = swap ? b0 : a0;
        q0 = swap ? a0 : b0;
        p1 = swap ? b1 : a1;
        q1 = swap ? a1 : b1;
        // order endpoints so the major coordinate rises
        if (p0 > p1) begin
            ma0 = p1; mi0 = q1; ma1 = p0; mi1 = q0;
        end else begin
            ma0 = p0; mi0 = q0; ma1 = p1; mi1 = q1;
        end
        dmin    = $signed({1'b0, mi1}) - $signed({1'b0, mi0});
        mag_min = dmin[CB] ? (CB+1)'(-dmin) : (CB+1)'(dmin);
    end

    always_comb begin
        acc_sum    = acc_reg + $signed({1'b0, incr_reg});
        span_ext   = $signed({2'b00, span_reg});
        minor_move = acc_sum > span_ext;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
        end else if (load_en) begin
            active_reg <= 1'b1;
        end else if (step_en && (major_pos_reg >= major_end_reg)) begin
            active_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_en) begin
            major_pos_reg <= ma0;
            major_end_reg <= ma1;
            minor_pos_reg <= mi0;
            span_reg      <= ma1 - ma0;
            incr_reg      <= {mag_min[CB-1:0], 1'b0};
            acc_reg       <= '0;
            step_down_reg <= !(mi1 > mi0);
            swapped_reg   <= swap;
            color_reg     <= color_in;
        end else if (step_en) begin
            if (minor_move) begin
                minor_pos_reg <= step_down_reg ? minor_pos_reg - CB'(1)
                                               : minor_pos_reg + CB'(1);
                acc_reg       <= acc_sum - (span_ext <<< 1);
            end else begin
                acc_reg <= acc_sum;
            end
            if (major_pos_reg < major_end_reg) begin
                major_pos_reg <= major_pos_reg + CB'(1);
            end
        end
    end

    assign active    = active_reg;
    assign pix_x     = swapped_reg ? minor_pos_reg : major_pos_reg;
    assign pix_y     = swapped_reg ? major_pos_reg : minor_pos_reg;
    assign pix_last  = major_pos_reg >= major_end_reg;
    assign color_out = color_reg;

`ifndef SYNTHESIS
    // error term stays within one span of zero while a line is drawn
    a_acc_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (acc_reg <= span_ext) && (acc_reg >= -span_ext))
        else $error("error term out of range");
`endif

endmodule

// ===== hw/rtl/blpg_addr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blpg_addr
// Bottom-up buffer address and frame bounds check for one pixel.
// ----------------------------------------------------------------------------
module blpg_addr
    import blpg_pkg::*;
#(
    parameter int CB = 13
)
(
    input  logic [CB-1:0]        pix_x,
    input  logic [CB-1:0]        pix_y,
    input  frame_cfg_t           frame_cfg,
    output logic [ADDR_BITS-1:0] address,
    output logic                 in_frame
);

    localparam int MW = (CB > CFG_BITS) ? CB : CFG_BITS;
    localparam int DW = MW + 1;
    localparam int PW = DW + CFG_BITS + 1;
    localparam int AW = PW + 1;

    logic signed [DW-1:0]       height_s;
    logic signed [DW-1:0]       y_s;
    logic signed [DW-1:0]       row;
    logic signed [CFG_BITS:0]   width_s;
    logic signed [PW-1:0]       row_base;
    logic signed [AW-1:0]       addr_full;

    always_comb begin
        height_s  = $signed({{(DW-CFG_BITS){1'b0}}, frame_cfg.height});
        y_s       = $signed({{(DW-CB){1'b0}}, pix_y});
        row       = height_s - y_s;
        width_s   = $signed({1'b0, frame_cfg.width});
        row_base  = PW'(row) * PW'(width_s);
        addr_full = AW'(row_base) + AW'($signed({1'b0, pix_x}));
    end

    assign address  = addr_full[ADDR_BITS-1:0];
    assign in_frame = !addr_full[AW-1] &&
                      (addr_full[AW-2:0] < (AW-1)'(frame_cfg.area));

endmodule

// ===== hw/rtl/bresenham_line_pixel_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bresenham_line_pixel_generator
// Bresenham line rasterizer producing bottom-up frame buffer pixels.
// ----------------------------------------------------------------------------
// Usage:
//   Write frame_width (index 0) and frame_height (index 1) on the cfg port
//   while the block is idle; they reset to 1024 and 768.
//   Input words (s_*) with action load latch two endpoints and a color and
//   give no output. Input words with action step give one pixel word (m_*)
//   each while a line is active, m_last marking the final pixel; a step
//   with no line active is dropped.
//   m_valid rises after a step word is accepted: the accepting edge fills
//   the input register, the advancing edge fills the output register.
//   Throughput is one word per cycle while m_ready holds, with the error
//   update and address multiply combinational between the two registers.
//   The input register takes a new word while a pixel waits on m_ready;
//   when both registers are full, s_ready drops until the receiver takes
//   the pixel.
//   Reset clears the line state (no line active) and empties both registers.
// ----------------------------------------------------------------------------
module bresenham_line_pixel_generator
    import blpg_pkg::*;
#(
    parameter int COORD_BITS = 13
)
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_action,
    input  logic signed [COORD_BITS-1:0] s_x_start,
    input  logic signed [COORD_BITS-1:0] s_y_start,
    input  logic signed [COORD_BITS-1:0] s_x_end,
    input  logic signed [COORD_BITS-1:0] s_y_end,
    input  logic [COLOR_BITS-1:0]   s_draw_color,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [ADDR_BITS-1:0]    m_pixel_address,
    output logic                    m_in_frame,
    output logic [CHAN_BITS-1:0]    m_red,
    output logic [CHAN_BITS-1:0]    m_green,
    output logic [CHAN_BITS-1:0]    m_blue,
    output logic                    m_last
);

    localparam int CB = COORD_BITS;

    frame_cfg_t frame_cfg;

    logic                  in_valid_reg;
    logic                  in_action_reg;
    logic signed [CB-1:0]  in_x_start_reg;
    logic signed [CB-1:0]  in_y_start_reg;
    logic signed [CB-1:0]  in_x_end_reg;
    logic signed [CB-1:0]  in_y_end_reg;
    logic [COLOR_BITS-1:0] in_color_reg;

    logic                  out_valid_reg;
    logic [ADDR_BITS-1:0]  out_addr_reg;
    logic                  out_in_frame_reg;
    logic [COLOR_BITS-1:0] out_color_reg;
    logic                  out_last_reg;

    logic                  out_free;
    logic                  advance;
    logic                  load_en;
    logic                  emit;
    logic                  line_active;
    logic [CB-1:0]         pix_x;
    logic [CB-1:0]         pix_y;
    logic                  pix_last;
    logic [COLOR_BITS-1:0] pix_color;
    logic [ADDR_BITS-1:0]  pix_addr;
    logic                  pix_in_frame;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign load_en  = advance && (in_action_reg == ACTION_LOAD);
    assign emit     = advance && (in_action_reg == ACTION_STEP) && line_active;
    assign s_ready  = !in_valid_reg || advance;

    blpg_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .frame_cfg (frame_cfg)
    );

    blpg_line #(.CB(CB)) u_line (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load_en   (load_en),
        .step_en   (emit),
        .x_start   (in_x_start_reg),
        .y_start   (in_y_start_reg),
        .x_end     (in_x_end_reg),
        .y_end     (in_y_end_reg),
        .color_in  (in_color_reg),
        .active    (line_active),
        .pix_x     (pix_x),
        .pix_y     (pix_y),
        .pix_last  (pix_last),
        .color_out (pix_color)
    );

    blpg_addr #(.CB(CB)) u_addr (
        .pix_x     (pix_x),
        .pix_y     (pix_y),
        .frame_cfg (frame_cfg),
        .address   (pix_addr),
        .in_frame  (pix_in_frame)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_action_reg  <= s_action;
            in_x_start_reg <= s_x_start;
            in_y_start_reg <= s_y_start;
            in_x_end_reg   <= s_x_end;
            in_y_end_reg   <= s_y_end;
            in_color_reg   <= s_draw_color;
        end
    end

    // output register: hold until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_addr_reg     <= pix_addr;
            out_in_frame_reg <= pix_in_frame;
            out_color_reg    <= pix_color;
            out_last_reg     <= pix_last;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_pixel_address = out_addr_reg;
    assign m_in_frame      = out_in_frame_reg;
    assign m_red           = out_color_reg[CHAN_BITS-1:0];
    assign m_green         = out_color_reg[2*CHAN_BITS-1:CHAN_BITS];
    assign m_blue          = out_color_reg[3*CHAN_BITS-1:2*CHAN_BITS];
    assign m_last          = out_last_reg;

`ifndef SYNTHESIS
    a_emit_active: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> line_active)
        else $error("pixel emitted with no line active");

    a_last_ends_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && pix_last) |=> !line_active)
        else $error("line still active after its last pixel");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |-> !emit)
        else $error("pending pixel overwritten");
`endif

endmodule
